// File: hdl/bfpa_pkg.sv
// shared types and constants of the best-fit partition allocator
package bfpa_pkg;

  localparam int KIND_W      = 1;
  localparam int BLK_PORT_W  = 4;
  localparam int SIZE_PORT_W = 16;
  localparam int NUM_PORT_W  = 8;
  localparam int CFG_W       = 5;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 1'b0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic load_we;
    logic req_start;
    logic rd_en;
    logic commit;
  } bfpa_cmd_t;

endpackage

// File: hdl/bfpa_ctrl.sv
// controller: request sequencing, scan address counter and search count register
module bfpa_ctrl import bfpa_pkg::*; #(
  parameter int NUM_BLOCKS = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  busy,
  output bfpa_cmd_t             cmd,
  output logic [IDX_W-1:0]      rd_addr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CFG_W-1:0]  blocks_in_use_r, blocks_in_use_nxt;
  logic [CNT_W-1:0]  limit;
  logic              accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign limit  = (32'(blocks_in_use_r) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(blocks_in_use_r);
  assign rd_addr = cnt_r[IDX_W-1:0];

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    blocks_in_use_nxt = cfg_we ? cfg_wdata : blocks_in_use_r;
    cmd               = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.req_start = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == limit) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.rd_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cnt_r           <= '0;
      blocks_in_use_r <= '0;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      blocks_in_use_r <= blocks_in_use_nxt;
    end
  end

endmodule

// File: hdl/bfpa_dpath.sv
// datapath: size memory, used flags, best-fit compare and result registers
module bfpa_dpath import bfpa_pkg::*; #(
  parameter int NUM_BLOCKS   = 16,
  parameter int SIZE_BITS    = 16,
  parameter int MAX_REQUESTS = 256,
  parameter int IDX_W        = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfpa_cmd_t              cmd,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic [BLK_PORT_W-1:0]  in_block_index,
  input  logic [SIZE_PORT_W-1:0] in_size_value,
  output logic                   out_valid,
  output logic                   out_granted,
  output logic [BLK_PORT_W-1:0]  out_chosen_block,
  output logic [NUM_PORT_W-1:0]  out_request_number
);

  localparam int SIZE_EXT_W = (SIZE_BITS > SIZE_PORT_W) ? SIZE_BITS : SIZE_PORT_W;
  localparam int ADDR_EXT_W = (IDX_W > BLK_PORT_W) ? IDX_W : BLK_PORT_W;
  localparam int REQ_W      = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int REQ_EXT_W  = (REQ_W > NUM_PORT_W) ? REQ_W : NUM_PORT_W;

  logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] used_r;

  logic [SIZE_EXT_W-1:0] size_ext;
  logic [SIZE_BITS-1:0]  in_size;
  logic [ADDR_EXT_W-1:0] addr_ext;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_in_range;

  logic [SIZE_BITS-1:0]  req_size_r;
  logic [SIZE_BITS-1:0]  rd_size_r;
  logic                  rd_used_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  rd_valid_r;

  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0]  best_size_r, best_size_nxt;
  logic                  better;

  logic [REQ_W-1:0]      req_cnt_r, req_cnt_nxt;
  logic [REQ_EXT_W-1:0]  req_cnt_ext;
  logic [ADDR_EXT_W-1:0] best_ext;

  logic                  out_valid_r;
  logic                  out_granted_r;
  logic [BLK_PORT_W-1:0] out_chosen_block_r;
  logic [NUM_PORT_W-1:0] out_request_number_r;

  assign size_ext    = SIZE_EXT_W'(in_size_value);
  assign in_size     = size_ext[SIZE_BITS-1:0];
  assign addr_ext    = ADDR_EXT_W'(in_block_index);
  assign wr_addr     = addr_ext[IDX_W-1:0];
  assign wr_in_range = (32'(in_block_index) < NUM_BLOCKS);

  // size memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_in_range) begin
      size_mem[wr_addr] <= in_size;
    end
    if (cmd.rd_en) begin
      rd_size_r <= size_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.load_we && wr_in_range) begin
      used_r[wr_addr] <= 1'b0;
    end else if (cmd.commit && found_r) begin
      used_r[best_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_start) begin
      req_size_r <= in_size;
    end
    if (cmd.rd_en) begin
      rd_used_r <= used_r[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  assign better = rd_valid_r && !rd_used_r && (rd_size_r >= req_size_r) &&
                  (!found_r || (rd_size_r < best_size_r));

  always_comb begin
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_size_nxt = best_size_r;
    if (cmd.req_start) begin
      found_nxt    = 1'b0;
      best_idx_nxt = '0;
    end else if (better) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = rd_idx_r;
      best_size_nxt = rd_size_r;
    end
  end

  always_comb begin
    req_cnt_nxt = req_cnt_r;
    if (cmd.commit) begin
      req_cnt_nxt = (32'(req_cnt_r) == MAX_REQUESTS - 1) ? '0 : req_cnt_r + REQ_W'(1);
    end
  end

  assign req_cnt_ext = REQ_EXT_W'(req_cnt_r);
  assign best_ext    = ADDR_EXT_W'(best_idx_r);

  always_ff @(posedge clk) begin
    best_size_r <= best_size_nxt;
    best_idx_r  <= best_idx_nxt;
    if (cmd.commit) begin
      out_granted_r        <= found_r;
      out_chosen_block_r   <= found_r ? best_ext[BLK_PORT_W-1:0] : '0;
      out_request_number_r <= req_cnt_ext[NUM_PORT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      req_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r  <= cmd.rd_en;
      found_r     <= found_nxt;
      req_cnt_r   <= req_cnt_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted        = out_granted_r;
  assign out_chosen_block   = out_chosen_block_r;
  assign out_request_number = out_request_number_r;

endmodule

// File: hdl/best_fit_partition_allocator.sv
// top level of the best-fit fixed-partition allocator
// usage:
//   input beat: start high while busy is low; in_kind selects a load (write
//   in_size_value into partition in_block_index and mark it free) or a
//   request (find the smallest free partition at least in_size_value).
//   loads give no result, go in one per cycle when idle, busy stays low.
//   a request raises busy, scans the first min(cfg, NUM_BLOCKS) partitions
//   one per cycle through the size memory read port, then commits.
//   request steps: a size memory read per partition, the read register,
//   then the commit state; out_valid is registered from the commit.
//   a new beat may be started in the cycle out_valid is high.
//   result beat: out_valid high for one cycle with out_granted,
//   out_chosen_block (0 if not granted) and out_request_number.
//   the receiver cannot stall; results must be taken when shown.
//   cfg_we/cfg_wdata write the search count; the user must do so only
//   while the block is idle, which the block itself does not enforce.
//   reset: used flags, request counter and search count clear to zero;
//   partition sizes are undefined until loaded.
module best_fit_partition_allocator import bfpa_pkg::*; #(
  parameter int NUM_BLOCKS   = 16,
  parameter int SIZE_BITS    = 16,
  parameter int MAX_REQUESTS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [BLK_PORT_W-1:0]  in_block_index,
  input  logic [SIZE_PORT_W-1:0] in_size_value,
  output logic                   out_valid,
  output logic                   out_granted,
  output logic [BLK_PORT_W-1:0]  out_chosen_block,
  output logic [NUM_PORT_W-1:0]  out_request_number,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  bfpa_cmd_t        cmd;
  logic [IDX_W-1:0] rd_addr;

  bfpa_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  bfpa_dpath #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .SIZE_BITS    (SIZE_BITS),
    .MAX_REQUESTS (MAX_REQUESTS),
    .IDX_W        (IDX_W)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .rd_addr            (rd_addr),
    .in_block_index     (in_block_index),
    .in_size_value      (in_size_value),
    .out_valid          (out_valid),
    .out_granted        (out_granted),
    .out_chosen_block   (out_chosen_block),
    .out_request_number (out_request_number)
  );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the best-fit fixed-partition allocator
`timescale 1ns / 1ps

module tb_top import bfpa_pkg::*; ();

  localparam int PARTITIONS   = 16;
  localparam int RANDOM_BEATS = 1250;
  localparam int SETTLE       = 25;
  localparam int STALL_LIMIT  = 500;

  typedef struct packed {
    logic                  granted;
    logic [BLK_PORT_W-1:0] block;
    logic [NUM_PORT_W-1:0] number;
  } grant_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_REQUEST, ROW_CONFIG} row_op_t;

  typedef struct packed {
    row_op_t                op;
    logic [BLK_PORT_W-1:0]  blk;
    logic [SIZE_PORT_W-1:0] size;
    logic [CFG_W-1:0]       cfg_val;
    logic                   pinned;
    grant_t                 want;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [KIND_W-1:0]      in_kind;
  logic [BLK_PORT_W-1:0]  in_block_index;
  logic [SIZE_PORT_W-1:0] in_size_value;
  logic                   out_valid;
  logic                   out_granted;
  logic [BLK_PORT_W-1:0]  out_chosen_block;
  logic [NUM_PORT_W-1:0]  out_request_number;
  logic                   cfg_we;
  logic [CFG_W-1:0]       cfg_wdata;

  // predictor state
  bit [SIZE_PORT_W-1:0] part_size [PARTITIONS];
  bit                   part_used [PARTITIONS];
  logic [NUM_PORT_W-1:0] req_count;
  logic [CFG_W-1:0]      search_count;
  grant_t                pending_grants [$];

  // fixed expectation for the directed beat being driven
  bit     pin_active;
  grant_t pin_grant;

  int mismatch_count;
  int load_total;
  int request_total;
  int grant_total;
  int config_total;
  int stall_cycles;

  row_t directed_rows [0:14] = '{
    '{ROW_REQUEST, 4'd0,  16'h0000, 5'd0, 1'b1, '{1'b0, 4'd0, 8'd0}},
    '{ROW_LOAD,    4'd0,  16'hFFFF, 5'd0, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_LOAD,    4'd1,  16'h0000, 5'd0, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_LOAD,    4'd2,  16'h1234, 5'd0, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_LOAD,    4'd3,  16'h1234, 5'd0, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_CONFIG,  4'd0,  16'h0000, 5'd1, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_REQUEST, 4'd15, 16'hFFFF, 5'd0, 1'b1, '{1'b1, 4'd0, 8'd1}},
    '{ROW_REQUEST, 4'd0,  16'h0000, 5'd0, 1'b1, '{1'b0, 4'd0, 8'd2}},
    '{ROW_LOAD,    4'd0,  16'hFFFF, 5'd0, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_CONFIG,  4'd0,  16'h0000, 5'd4, 1'b0, '{1'b0, 4'd0, 8'd0}},
    '{ROW_REQUEST, 4'd0,  16'h1234, 5'd0, 1'b1, '{1'b1, 4'd2, 8'd3}},
    '{ROW_REQUEST, 4'd0,  16'h1234, 5'd0, 1'b1, '{1'b1, 4'd3, 8'd4}},
    '{ROW_REQUEST, 4'd0,  16'h1235, 5'd0, 1'b1, '{1'b1, 4'd0, 8'd5}},
    '{ROW_REQUEST, 4'd0,  16'h0000, 5'd0, 1'b1, '{1'b1, 4'd1, 8'd6}},
    '{ROW_REQUEST, 4'd0,  16'h0000, 5'd0, 1'b1, '{1'b0, 4'd0, 8'd7}}
  };

  best_fit_partition_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_block_index     (in_block_index),
    .in_size_value      (in_size_value),
    .out_valid          (out_valid),
    .out_granted        (out_granted),
    .out_chosen_block   (out_chosen_block),
    .out_request_number (out_request_number),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic grant_t allocate_request(input logic [SIZE_PORT_W-1:0] want_size);
    grant_t r;
    int     lim;
    int     best;
    int     j;
    bit     found;
    lim   = (search_count > PARTITIONS) ? PARTITIONS : int'(search_count);
    best  = 0;
    found = 1'b0;
    for (j = 0; j < lim; j++) begin
      if (!part_used[j] && part_size[j] >= want_size) begin
        if (!found || part_size[j] < part_size[best]) begin
          best  = j;
          found = 1'b1;
        end
      end
    end
    if (found) part_used[best] = 1'b1;
    r.granted = found;
    r.block   = found ? 4'(best) : '0;
    r.number  = req_count;
    req_count = req_count + 8'd1;
    return r;
  endfunction

  task automatic check_result();
    grant_t exp_g;
    if (pending_grants.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t unexpected result: granted=%0b block=%0d number=%0d", $realtime,
                 out_granted, out_chosen_block, out_request_number);
    end else begin
      exp_g = pending_grants.pop_front();
      if (out_granted !== exp_g.granted || out_chosen_block !== exp_g.block ||
          out_request_number !== exp_g.number) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t mismatch: expected granted=%0b block=%0d number=%0d, got %0b %0d %0d",
                   $realtime, exp_g.granted, exp_g.block, exp_g.number,
                   out_granted, out_chosen_block, out_request_number);
      end
    end
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      for (int k = 0; k < PARTITIONS; k++) part_used[k] = 1'b0;
      req_count    = '0;
      search_count = '0;
      pending_grants.delete();
    end else begin
      if (out_valid) check_result();
      if (cfg_we) search_count = cfg_wdata;
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          part_size[in_block_index] = in_size_value;
          part_used[in_block_index] = 1'b0;
          load_total++;
        end else begin
          g = allocate_request(in_size_value);
          if (pin_active) g = pin_grant;
          pending_grants.push_back(g);
          request_total++;
          if (g.granted) grant_total++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic drive_beat(input logic [KIND_W-1:0] k, input logic [BLK_PORT_W-1:0] b,
                            input logic [SIZE_PORT_W-1:0] s, input bit with_gaps);
    int gap;
    gap = with_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_kind        <= k;
    in_block_index <= b;
    in_size_value  <= s;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_search_count(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    config_total++;
  endtask

  function automatic logic [SIZE_PORT_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_PORT_W'($urandom);
      4, 5:    return SIZE_PORT_W'($urandom_range(0, 15) << 12);
      default: return SIZE_PORT_W'($urandom_range(0, 64));
    endcase
  endfunction

  initial begin
    int               sent;
    int               phase;
    int               n;
    int               i;
    bit               gaps_on;
    logic [CFG_W-1:0] cfg_pick;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_LOAD;
    in_block_index = '0;
    in_size_value  = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    pin_active     = 1'b0;
    pin_grant      = '0;
    mismatch_count = 0;
    load_total     = 0;
    request_total  = 0;
    grant_total    = 0;
    config_total   = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    for (i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].op == ROW_CONFIG) begin
        write_search_count(directed_rows[i].cfg_val);
      end else begin
        pin_active = directed_rows[i].pinned;
        pin_grant  = directed_rows[i].want;
        drive_beat((directed_rows[i].op == ROW_LOAD) ? KIND_LOAD : KIND_REQUEST,
                   directed_rows[i].blk, directed_rows[i].size, 1'b1);
      end
    end
    pin_active = 1'b0;

    // random phases, each under one search count
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      case (phase)
        0:       cfg_pick = 5'd16;
        1:       cfg_pick = 5'd31;
        2:       cfg_pick = 5'd0;
        3:       cfg_pick = 5'd1;
        4:       cfg_pick = 5'd17;
        default: cfg_pick = ($urandom_range(0, 9) < 7) ? 5'd16 : CFG_W'($urandom_range(0, 31));
      endcase
      write_search_count(cfg_pick);
      gaps_on = (phase % 4 != 1);
      n = $urandom_range(30, 70);
      // fill every partition first so no search reaches an unloaded size
      if (phase == 0) begin
        for (i = 0; i < PARTITIONS; i++) begin
          drive_beat(KIND_LOAD, BLK_PORT_W'(i), pick_size(), gaps_on);
          sent++;
        end
      end
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) < 4)
          drive_beat(KIND_LOAD, BLK_PORT_W'($urandom_range(0, 15)), pick_size(), gaps_on);
        else
          drive_beat(KIND_REQUEST, BLK_PORT_W'($urandom_range(0, 15)), pick_size(), gaps_on);
        sent++;
      end
      phase++;
    end

    start <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    mismatch_count += pending_grants.size();

    $display("covered %0d loads and %0d requests (%0d granted, %0d refused)",
             load_total, request_total, grant_total, request_total - grant_total);
    $display("over %0d search-count settings, %0d mismatches", config_total, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: best_fit_partition_allocator.f
hdl/bfpa_pkg.sv
hdl/bfpa_ctrl.sv
hdl/bfpa_dpath.sv
hdl/best_fit_partition_allocator.sv
tb/tb_top.sv
